### rtl/pva_pkg.sv
package pva_pkg;

    localparam int CORDIC_STAGES = 20;
    localparam int FRAC_BITS     = 8;
    localparam int GUARD_BITS    = 16;
    localparam int ANGLE_Q       = 32;
    localparam int CW            = 44;
    localparam int MAG_W         = 40;
    localparam int FOLD_W        = 17;
    localparam int LEN_W         = 24;
    localparam int ANG_W         = 18;
    localparam int SUM_LEN_W     = 25;
    localparam int SUM_ANG_W     = 17;
    localparam int ATAN_ENTRIES  = 32;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam int FULL_TURN     = 360 << FRAC_BITS;
    localparam int HALF_TURN     = 180 << FRAC_BITS;
    localparam int QUARTER_TURN  = 90 << FRAC_BITS;

    localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

    typedef logic signed [CW-1:0] t_comp;
    typedef t_comp t_atan_tab [ATAN_ENTRIES];

    typedef struct packed {
        logic [MAG_W-1:0]         mag;
        logic                     neg;
        logic signed [FOLD_W-1:0] ang;
    } t_vec;

    typedef struct packed {
        t_vec vec_a;
        t_vec vec_b;
    } t_item;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } t_q_stat;

    // shift-subtract divide, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int k = 63; k >= 0; k--) begin
            r = {r[62:0], num[k]};
            if (r >= den) begin
                r = r - den;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/m) in Q62 by the arctangent series
    function automatic logic [63:0] atan_recip(input logic [63:0] m);
        logic [63:0] p;
        logic [63:0] m2;
        logic [63:0] n;
        logic [63:0] acc;
        logic [63:0] t;
        logic        neg;
        p   = udiv64(64'd1 << 62, m);
        m2  = m * m;
        n   = 64'd1;
        acc = '0;
        neg = 1'b0;
        for (int k = 0; k < 64; k++) begin
            if (p != 0) begin
                t   = udiv64(p, n);
                acc = neg ? acc - t : acc + t;
                p   = udiv64(p, m2);
                n   = n + 64'd2;
                neg = !neg;
            end
        end
        return acc;
    endfunction

    // atan(2^-i) in degrees, Q32, truncated
    function automatic t_atan_tab build_atan();
        t_atan_tab   tab;
        logic [63:0] quarter;
        logic [63:0] a;
        logic [63:0] q;
        quarter = 64'd4 * atan_recip(64'd5) - atan_recip(64'd239);
        tab[0]  = CW'(64'd45 << ANGLE_Q);
        for (int i = 1; i < ATAN_ENTRIES; i++) begin
            a = atan_recip(64'd1 << i);
            q = '0;
            for (int k = 0; k < ANGLE_Q; k++) begin
                a = a << 1;
                q = q << 1;
                if (a >= quarter) begin
                    a = a - quarter;
                    q = q | 64'd1;
                end
            end
            tab[i] = CW'(q * 64'd45);
        end
        return tab;
    endfunction

    localparam t_atan_tab ATAN_DEG = build_atan();

endpackage

### rtl/pva_front.sv
module pva_front (
    input  logic [pva_pkg::LEN_W-1:0]        i_len_a,
    input  logic signed [pva_pkg::ANG_W-1:0] i_ang_a,
    input  logic [pva_pkg::LEN_W-1:0]        i_len_b,
    input  logic signed [pva_pkg::ANG_W-1:0] i_ang_b,
    output pva_pkg::t_item                   o_item
);
    import pva_pkg::*;

    localparam logic signed [ANG_W:0] FULL_C    = (ANG_W+1)'(FULL_TURN);
    localparam logic signed [ANG_W:0] HALF_C    = (ANG_W+1)'(HALF_TURN);
    localparam logic signed [ANG_W:0] QUARTER_C = (ANG_W+1)'(QUARTER_TURN);

    // reduce to (-180,180], then fold into [-90,90] with a sign flip
    function automatic t_vec classify(input logic [LEN_W-1:0] len,
                                      input logic signed [ANG_W-1:0] ang);
        t_vec                  v;
        logic signed [ANG_W:0] a;
        logic [63:0]           prod;
        a = (ANG_W+1)'(ang);
        if (a < 0) a = a + FULL_C;
        if (a < 0) a = a + FULL_C;
        if (a >= FULL_C) a = a - FULL_C;
        if (a > HALF_C) a = a - FULL_C;
        v.neg = 1'b0;
        if (a > QUARTER_C) begin
            a     = a - HALF_C;
            v.neg = 1'b1;
        end else if (a < -QUARTER_C) begin
            a     = a + HALF_C;
            v.neg = 1'b1;
        end
        prod  = {{(64-LEN_W){1'b0}}, len} * {32'b0, GAIN_Q32};
        v.mag = prod[MAG_W+GUARD_BITS-1:GUARD_BITS];
        v.ang = a[FOLD_W-1:0];
        return v;
    endfunction

    always_comb begin
        o_item.vec_a = classify(i_len_a, i_ang_a);
        o_item.vec_b = classify(i_len_b, i_ang_b);
    end

endmodule

### rtl/pva_queue.sv
module pva_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pva_pkg::t_item   i_item,
    input  logic             i_pop,
    output pva_pkg::t_item   o_item,
    output pva_pkg::t_q_stat o_stat
);
    import pva_pkg::*;

    t_item               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_count;
    logic [QPTR_W-1:0]   n_wr;
    logic [QPTR_W-1:0]   n_rd;
    logic [QCNT_W-1:0]   n_count;

    always_comb begin
        n_wr    = i_push ? QPTR_W'(r_wr + 1'b1) : r_wr;
        n_rd    = i_pop  ? QPTR_W'(r_rd + 1'b1) : r_rd;
        n_count = r_count;
        if (i_push && !i_pop) n_count = QCNT_W'(r_count + 1'b1);
        if (!i_push && i_pop) n_count = QCNT_W'(r_count - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr] <= i_item;
    end

    assign o_item       = r_slot[r_rd];
    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

### rtl/pva_back.sv
module pva_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pva_pkg::t_item                     i_item,
    input  logic                               i_avail,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [pva_pkg::SUM_LEN_W-1:0]      o_sum_length,
    output logic signed [pva_pkg::SUM_ANG_W-1:0] o_sum_angle
);
    import pva_pkg::*;

    localparam int N      = CORDIC_STAGES;
    localparam int L      = 2 * N + 5;
    localparam int SH     = ANGLE_Q - FRAC_BITS;
    localparam int ZR_W   = CW - SH;
    localparam int MSUM_W = CW + 1;
    localparam int RND_W  = MSUM_W - GUARD_BITS;

    localparam t_comp DEG180 = t_comp'(64'd180 << ANGLE_Q);
    localparam t_comp ZROUND = t_comp'(64'd1 << (SH - 1));
    localparam logic signed [ZR_W-1:0] FULL_Z = ZR_W'(FULL_TURN);
    localparam logic signed [ZR_W-1:0] HALF_Z = ZR_W'(HALF_TURN);
    localparam logic [RND_W-1:0] LEN_MAX = RND_W'({SUM_LEN_W{1'b1}});

    logic en;
    logic [L-1:0] r_vld;

    t_comp r_x1 [N+1];
    t_comp r_y1 [N+1];
    t_comp r_z1 [N+1];
    t_comp r_x2 [N+1];
    t_comp r_y2 [N+1];
    t_comp r_z2 [N+1];
    t_comp r_sx;
    t_comp r_sy;
    t_comp r_vx [N+1];
    t_comp r_vy [N+1];
    t_comp r_vz [N+1];
    logic [N:0] r_vzero;

    logic [CW-1:0]              r_phi;
    logic [31:0]                r_plo;
    logic                       r_pos;
    logic signed [SUM_ANG_W-1:0] r_ang1;
    logic [MSUM_W-1:0]          r_msum;
    logic signed [SUM_ANG_W-1:0] r_ang2;
    logic                       r_out_valid;
    logic [SUM_LEN_W-1:0]       r_out_len;
    logic signed [SUM_ANG_W-1:0] r_out_ang;

    assign en    = !r_out_valid || i_ready;
    assign o_pop = en && i_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[L-2:0], o_pop};
            r_out_valid <= r_vld[L-1];
        end
    end

    // load both vectors: apply the fold sign, angle to Q32 degrees
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x1[0] <= i_item.vec_a.neg ? -t_comp'(i_item.vec_a.mag) : t_comp'(i_item.vec_a.mag);
            r_y1[0] <= '0;
            r_z1[0] <= t_comp'(i_item.vec_a.ang) <<< SH;
            r_x2[0] <= i_item.vec_b.neg ? -t_comp'(i_item.vec_b.mag) : t_comp'(i_item.vec_b.mag);
            r_y2[0] <= '0;
            r_z2[0] <= t_comp'(i_item.vec_b.ang) <<< SH;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        t_comp dx1, dy1, dx2, dy2;
        assign dx1 = r_y1[i] >>> i;
        assign dy1 = r_x1[i] >>> i;
        assign dx2 = r_y2[i] >>> i;
        assign dy2 = r_x2[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_z1[i] >= 0) begin
                    r_x1[i+1] <= r_x1[i] - dx1;
                    r_y1[i+1] <= r_y1[i] + dy1;
                    r_z1[i+1] <= r_z1[i] - ATAN_DEG[i];
                end else begin
                    r_x1[i+1] <= r_x1[i] + dx1;
                    r_y1[i+1] <= r_y1[i] - dy1;
                    r_z1[i+1] <= r_z1[i] + ATAN_DEG[i];
                end
                if (r_z2[i] >= 0) begin
                    r_x2[i+1] <= r_x2[i] - dx2;
                    r_y2[i+1] <= r_y2[i] + dy2;
                    r_z2[i+1] <= r_z2[i] - ATAN_DEG[i];
                end else begin
                    r_x2[i+1] <= r_x2[i] + dx2;
                    r_y2[i+1] <= r_y2[i] - dy2;
                    r_z2[i+1] <= r_z2[i] + ATAN_DEG[i];
                end
            end
        end
    end

    // add components, then move a left half-plane sum into the right half
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx <= r_x1[N] + r_x2[N];
            r_sy <= r_y1[N] + r_y2[N];
            r_vzero[0] <= (r_sx == '0) && (r_sy == '0);
            if (r_sx < 0) begin
                r_vx[0] <= -r_sx;
                r_vy[0] <= -r_sy;
                r_vz[0] <= (r_sy >= 0) ? DEG180 : -DEG180;
            end else begin
                r_vx[0] <= r_sx;
                r_vy[0] <= r_sy;
                r_vz[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_vec
        t_comp dx, dy;
        assign dx = r_vy[i] >>> i;
        assign dy = r_vx[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_vzero[i+1] <= r_vzero[i];
                if (r_vy[i] >= 0) begin
                    r_vx[i+1] <= r_vx[i] + dx;
                    r_vy[i+1] <= r_vy[i] - dy;
                    r_vz[i+1] <= r_vz[i] + ATAN_DEG[i];
                end else begin
                    r_vx[i+1] <= r_vx[i] - dx;
                    r_vy[i+1] <= r_vy[i] + dy;
                    r_vz[i+1] <= r_vz[i] - ATAN_DEG[i];
                end
            end
        end
    end

    // gain correction split at bit 32, angle rounding and wrap
    logic [63:0]             plo_full;
    logic [CW-1:0]           phi_full;
    t_comp                   z_rnd;
    logic signed [ZR_W-1:0]  z_deg;
    logic signed [ZR_W-1:0]  z_wrap;
    logic [RND_W-1:0]        len_rnd;

    always_comb begin
        plo_full = {32'b0, r_vx[N][31:0]} * {32'b0, GAIN_Q32};
        phi_full = CW'({{(CW-12){1'b0}}, r_vx[N][CW-1:32]} * {{(CW-32){1'b0}}, GAIN_Q32});
        z_rnd    = (r_vz[N] + ZROUND) >>> SH;
        z_deg    = z_rnd[ZR_W-1:0];
        z_wrap   = z_deg;
        if (z_deg > HALF_Z) z_wrap = z_deg - FULL_Z;
        if (z_deg <= -HALF_Z) z_wrap = z_deg + FULL_Z;
        len_rnd  = RND_W'((r_msum + MSUM_W'(1 << (GUARD_BITS - 1))) >> GUARD_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_phi  <= phi_full;
            r_plo  <= plo_full[63:32];
            r_pos  <= !r_vzero[N] && !r_vx[N][CW-1] && (r_vx[N] != '0);
            r_ang1 <= r_vzero[N] ? '0 : z_wrap[SUM_ANG_W-1:0];
            r_msum <= r_pos ? (MSUM_W'(r_phi) + MSUM_W'(r_plo)) : '0;
            r_ang2 <= r_ang1;
            if (r_vld[L-1]) begin
                r_out_len <= (len_rnd > LEN_MAX) ? {SUM_LEN_W{1'b1}} : len_rnd[SUM_LEN_W-1:0];
                r_out_ang <= r_ang2;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sum_length = r_out_len;
    assign o_sum_angle  = r_out_ang;

endmodule

### rtl/polar_vector_adder.sv
// Path: queue, load, rotation stages, component sum, vectoring stages, gain, rounded output.
// Throughput: one request per cycle unless stalled; three CORDICs fully unrolled by stage.
// A four-entry queue parts the classifying front from the CORDIC back end.
// Reset (i_rst_n low, synchronous): empties the queue and drops all in-flight requests.
module polar_vector_adder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // first_length[23:0], first_angle[41:24], second_length[65:42],
    // second_angle[83:66], zero fill [87:84]
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sum_length[24:0], sum_angle[41:25], zero fill [47:42]
    output logic [47:0] m_axis_tdata
);
    import pva_pkg::*;

    t_item   front_item;
    t_item   head_item;
    t_q_stat q_stat;
    logic    q_push;
    logic    q_pop;
    logic [SUM_LEN_W-1:0]        sum_length;
    logic signed [SUM_ANG_W-1:0] sum_angle;

    // accept whenever the queue has a free slot
    assign s_axis_tready = !q_stat.full;
    assign q_push        = s_axis_tvalid && s_axis_tready;

    // reduce angles, fold to the right half plane, prescale lengths by the gain
    pva_front u_front (
        .i_len_a (s_axis_tdata[23:0]),
        .i_ang_a (s_axis_tdata[41:24]),
        .i_len_b (s_axis_tdata[65:42]),
        .i_ang_b (s_axis_tdata[83:66]),
        .o_item  (front_item)
    );

    // hold classified requests until the back end can advance
    pva_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_item  (head_item),
        .o_stat  (q_stat)
    );

    // rotation CORDICs, component sum, vectoring CORDIC, gain and rounding
    pva_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (head_item),
        .i_avail      (!q_stat.empty),
        .o_pop        (q_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_sum_length (sum_length),
        .o_sum_angle  (sum_angle)
    );

    assign m_axis_tdata = {6'b0, sum_angle, sum_length};

`ifndef SYNTH
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && !q_pop) |=> !q_stat.empty)
        else $error("pushed request lost");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[41:25]) > -17'sd46080 &&
                           $signed(m_axis_tdata[41:25]) <= 17'sd46080))
        else $error("result angle out of range");
`endif

endmodule
